// ===== rtl/tpbc_pkg.sv =====
// Package for the tilt PID balance controller.
// Shared constants, command types, the arctangent table and the gain bundle.
// No dependencies.
package tpbc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SUM_BITS     = 32;

    localparam int STEP_W    = $clog2((CORDIC_STEPS > 16) ? CORDIC_STEPS : 16);
    localparam int SQRT_ITER = 16;
    localparam int CW        = 27;               // CORDIC x/y width
    localparam int ACW       = SUM_BITS + 18;    // PID accumulator width

    localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SQRT_ITER - 1);
    localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);

    // degrees = round(|z| * 1260 / (22 * 2^22))
    localparam logic [10:0] DEG_MUL    = 11'd1260;
    localparam logic [42:0] DEG_BIAS   = 43'd46137344;     // 11 * 2^22
    localparam logic [25:0] DEG_RECIP  = 26'd48806447;     // ceil(2^30 / 22)
    localparam logic [16:0] TILT_MAX   = 17'd23040;
    // drive = floor(|out| * 255 / (90 * 2^16))
    localparam logic [22:0] DRV_FULL   = 23'd5898240;
    localparam logic [17:0] DRV_RECIP  = 18'd186414;       // ceil(2^24 / 90)
    localparam logic [7:0]  DRV_MAX    = 8'd255;

    localparam logic [1:0] REG_GAIN_PROP   = 2'd0;
    localparam logic [1:0] REG_GAIN_INTEG  = 2'd1;
    localparam logic [1:0] REG_GAIN_DERIV  = 2'd2;
    localparam logic [1:0] REG_TARGET_TILT = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT,
        OP_CINIT,
        OP_CORDIC,
        OP_DMUL,
        OP_DDIV,
        OP_TILT,
        OP_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_AMAG,
        OP_SCALE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              drv;    // final drive divide
        logic              out;    // load result register
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] gain_prop;
        logic signed [15:0] gain_integ;
        logic signed [15:0] gain_deriv;
        logic signed [15:0] target_tilt;
    } t_gains;

    function automatic logic signed [31:0] atan_at(input logic [STEP_W-1:0] idx);
        logic signed [31:0] v;
        case (5'(idx))
            5'd0:  v = 32'sd843314856;
            5'd1:  v = 32'sd497837829;
            5'd2:  v = 32'sd263043836;
            5'd3:  v = 32'sd133525158;
            5'd4:  v = 32'sd67021686;
            5'd5:  v = 32'sd33543515;
            5'd6:  v = 32'sd16775850;
            5'd7:  v = 32'sd8388437;
            5'd8:  v = 32'sd4194282;
            5'd9:  v = 32'sd2097149;
            5'd10: v = 32'sd1048575;
            5'd11: v = 32'sd524287;
            5'd12: v = 32'sd262143;
            5'd13: v = 32'sd131071;
            5'd14: v = 32'sd65535;
            5'd15: v = 32'sd32767;
            5'd16: v = 32'sd16383;
            5'd17: v = 32'sd8191;
            5'd18: v = 32'sd4095;
            5'd19: v = 32'sd2047;
            5'd20: v = 32'sd1023;
            5'd21: v = 32'sd511;
            5'd22: v = 32'sd255;
            5'd23: v = 32'sd127;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tpbc_regs.sv =====
// Configuration register file: gains and target tilt behind an APB-style port.
// Depends on tpbc_pkg.
module tpbc_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output tpbc_pkg::t_gains     o_gains
);

    tpbc_pkg::t_gains r_gains;
    logic             w_wr;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite;
    assign o_gains = r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                tpbc_pkg::REG_GAIN_PROP:   r_gains.gain_prop   <= pwdata[15:0];
                tpbc_pkg::REG_GAIN_INTEG:  r_gains.gain_integ  <= pwdata[15:0];
                tpbc_pkg::REG_GAIN_DERIV:  r_gains.gain_deriv  <= pwdata[15:0];
                tpbc_pkg::REG_TARGET_TILT: r_gains.target_tilt <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tpbc_pkg::REG_GAIN_PROP:   prdata = {16'd0, r_gains.gain_prop};
            tpbc_pkg::REG_GAIN_INTEG:  prdata = {16'd0, r_gains.gain_integ};
            tpbc_pkg::REG_GAIN_DERIV:  prdata = {16'd0, r_gains.gain_deriv};
            tpbc_pkg::REG_TARGET_TILT: prdata = {16'd0, r_gains.target_tilt};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/tpbc_ctrl.sv =====
// Sequencer: steps the datapath through square, root, CORDIC, degrees, PID and drive.
// Depends on tpbc_pkg.
module tpbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpbc_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQY, S_SQZ, S_SQRT, S_CINIT, S_CORD, S_DMUL, S_DDIV, S_TILT,
        S_ERR, S_MP, S_MI, S_MD, S_AMAG, S_SCALE, S_DRV, S_OUT
    } t_state;

    t_state                          r_state, n_state;
    logic [tpbc_pkg::STEP_W-1:0]     r_cnt, n_cnt;
    logic                            r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid & ~i_out_ready;
        o_cmd    = '{op: tpbc_pkg::OP_NONE, drv: 1'b0, out: 1'b0, step: r_cnt};
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = tpbc_pkg::OP_LOAD;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = tpbc_pkg::OP_SQ_Y;
                n_state  = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.op = tpbc_pkg::OP_SQ_Z;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = tpbc_pkg::OP_SQRT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == tpbc_pkg::SQRT_LAST) n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.op = tpbc_pkg::OP_CINIT;
                n_cnt    = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                o_cmd.op = tpbc_pkg::OP_CORDIC;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == tpbc_pkg::CORDIC_LAST) n_state = S_DMUL;
            end
            S_DMUL:  begin o_cmd.op = tpbc_pkg::OP_DMUL;   n_state = S_DDIV;  end
            S_DDIV:  begin o_cmd.op = tpbc_pkg::OP_DDIV;   n_state = S_TILT;  end
            S_TILT:  begin o_cmd.op = tpbc_pkg::OP_TILT;   n_state = S_ERR;   end
            S_ERR:   begin o_cmd.op = tpbc_pkg::OP_ERR;    n_state = S_MP;    end
            S_MP:    begin o_cmd.op = tpbc_pkg::OP_MUL_P;  n_state = S_MI;    end
            S_MI:    begin o_cmd.op = tpbc_pkg::OP_MUL_I;  n_state = S_MD;    end
            S_MD:    begin o_cmd.op = tpbc_pkg::OP_MUL_D;  n_state = S_AMAG;  end
            S_AMAG:  begin o_cmd.op = tpbc_pkg::OP_AMAG;   n_state = S_SCALE; end
            S_SCALE: begin o_cmd.op = tpbc_pkg::OP_SCALE;  n_state = S_DRV;   end
            S_DRV:   begin o_cmd.drv = 1'b1;               n_state = S_OUT;   end
            S_OUT: if (!r_ovalid || i_out_ready) begin
                o_cmd.out = 1'b1;
                n_ovalid  = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== rtl/tpbc_dp.sv =====
// Datapath: magnitude, bit-serial root, CORDIC, degree scaling, PID and drive.
// Depends on tpbc_pkg; driven by tpbc_ctrl commands.
module tpbc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpbc_pkg::t_cmd       i_cmd,
    input  tpbc_pkg::t_gains     i_gains,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    output logic signed [15:0]   o_tilt_deg,
    output logic [7:0]           o_drive_level,
    output logic                 o_go_forward
);

    localparam int SB  = tpbc_pkg::SUM_BITS;
    localparam int CW  = tpbc_pkg::CW;
    localparam int ACW = tpbc_pkg::ACW;
    localparam logic signed [SB:0] SUM_MAX = (SB+1)'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [SB:0] SUM_MIN = (SB+1)'(-(64'sd1 <<< (SB - 1)));

    logic signed [15:0]   r_ax, r_ay, r_az;
    logic [31:0]          r_sq, r_rad;
    logic [16:0]          r_rem;
    logic [15:0]          r_root;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [31:0]   r_z;
    logic [42:0]          r_m;
    logic [16:0]          r_dq;
    logic signed [15:0]   r_tilt;
    logic signed [17:0]   r_err, r_prev;
    logic signed [SB-1:0] r_sum;
    logic signed [18:0]   r_der;
    logic signed [ACW-1:0] r_acc;
    logic [22:0]          r_amag;
    logic                 r_over;
    logic [14:0]          r_st;
    logic [7:0]           r_drive;

    logic signed [31:0]   w_ysq, w_zsq;
    logic [18:0]          w_rem2, w_trial;
    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [31:0]   w_atan;
    logic [31:0]          w_zmag;
    logic [46:0]          w_dprod;
    logic [16:0]          w_qc;
    logic signed [17:0]   w_err;
    logic signed [SB:0]   w_sum, w_sat;
    logic signed [33:0]   w_pe;
    logic signed [SB+15:0] w_pi;
    logic signed [34:0]   w_pd;
    logic signed [ACW-1:0] w_abs;
    logic [30:0]          w_s31;
    logic [32:0]          w_vprod;

    assign w_ysq   = r_ay * r_ay;
    assign w_zsq   = r_az * r_az;
    assign w_rem2  = {r_rem, r_rad[31:30]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_xs    = r_x >>> i_cmd.step;
    assign w_ys    = r_y >>> i_cmd.step;
    assign w_atan  = tpbc_pkg::atan_at(i_cmd.step);
    assign w_zmag  = r_z[31] ? 32'(-r_z) : 32'(r_z);
    assign w_dprod = 47'(r_m[42:22]) * 47'(tpbc_pkg::DEG_RECIP);
    assign w_qc    = (r_dq > tpbc_pkg::TILT_MAX) ? tpbc_pkg::TILT_MAX : r_dq;
    assign w_err   = 18'(i_gains.target_tilt) - 18'(r_tilt);
    assign w_sum   = (SB+1)'(r_sum) + (SB+1)'(w_err);
    assign w_sat   = (w_sum > SUM_MAX) ? SUM_MAX : ((w_sum < SUM_MIN) ? SUM_MIN : w_sum);
    assign w_pe    = i_gains.gain_prop * r_err;
    assign w_pi    = i_gains.gain_integ * r_sum;
    assign w_pd    = i_gains.gain_deriv * r_der;
    assign w_abs   = r_acc[ACW-1] ? -r_acc : r_acc;
    assign w_s31   = {r_amag, 8'd0} - 31'(r_amag);
    assign w_vprod = 33'(r_st) * 33'(tpbc_pkg::DRV_RECIP);

    // PID state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_cmd.op == tpbc_pkg::OP_ERR) begin
            r_sum  <= SB'(w_sat);
            r_prev <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tpbc_pkg::OP_LOAD: begin
                r_ax <= i_accel_x;
                r_ay <= i_accel_y;
                r_az <= i_accel_z;
            end
            tpbc_pkg::OP_SQ_Y: begin
                r_sq   <= 32'(w_ysq);
                r_rem  <= '0;
                r_root <= '0;
            end
            tpbc_pkg::OP_SQ_Z: r_rad <= r_sq + 32'(w_zsq);
            tpbc_pkg::OP_SQRT: begin
                r_rad <= {r_rad[29:0], 2'b00};
                if (w_rem2 >= w_trial) begin
                    r_rem  <= 17'(w_rem2 - w_trial);
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_rem  <= 17'(w_rem2);
                    r_root <= {r_root[14:0], 1'b0};
                end
            end
            tpbc_pkg::OP_CINIT: begin
                r_x <= CW'({r_root, 8'd0});
                r_y <= CW'($signed({r_ax, 8'd0}));
                r_z <= '0;
            end
            tpbc_pkg::OP_CORDIC: begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
            end
            tpbc_pkg::OP_DMUL:
                r_m <= 43'(w_zmag[30:0]) * 43'(tpbc_pkg::DEG_MUL) + tpbc_pkg::DEG_BIAS;
            tpbc_pkg::OP_DDIV: r_dq <= w_dprod[46:30];
            tpbc_pkg::OP_TILT: begin
                if (r_ax == 16'sd0)
                    r_tilt <= '0;
                else if (r_z[31])
                    r_tilt <= 16'(-$signed({1'b0, w_qc}));
                else
                    r_tilt <= 16'(w_qc);
            end
            tpbc_pkg::OP_ERR: begin
                r_err <= w_err;
                r_der <= 19'(w_err) - 19'(r_prev);
            end
            tpbc_pkg::OP_MUL_P: r_acc <= ACW'(w_pe);
            tpbc_pkg::OP_MUL_I: r_acc <= r_acc + ACW'(w_pi);
            tpbc_pkg::OP_MUL_D: r_acc <= r_acc + ACW'(w_pd);
            tpbc_pkg::OP_AMAG: begin
                r_over <= (w_abs > ACW'(tpbc_pkg::DRV_FULL));
                r_amag <= w_abs[22:0];
            end
            tpbc_pkg::OP_SCALE: r_st <= w_s31[30:16];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drv)
            r_drive <= r_over ? tpbc_pkg::DRV_MAX : w_vprod[31:24];
        if (i_cmd.out) begin
            o_tilt_deg    <= r_tilt;
            o_drive_level <= r_drive;
            o_go_forward  <= (r_tilt > 16'sd0);
        end
    end

endmodule

// ===== rtl/tilt_pid_balance_controller_top.sv =====
// Takes one accelerometer sample per transaction and returns pitch in Q8.8
// degrees with a PID drive level and direction flag. Each sample goes
// through the squares, the bit-serial square root, the CORDIC setup and its
// CORDIC_STEPS rotations, degree scaling, PID multiplies, drive scaling and
// the output register load; one sample is worked at a time, so a new sample
// is taken only once the last one has been loaded into the output register.
// A finished result waits in the output register while the next sample is
// taken; a result still held there stalls the next one before its output
// load. Gains and target sit at byte addresses 0, 4, 8 and 12.
// Depends on tpbc_pkg, tpbc_regs, tpbc_ctrl, tpbc_dp.
module tilt_pid_balance_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // tilt_deg, drive_level
    output logic        m_axis_tuser    // go_forward
);

    tpbc_pkg::t_gains w_gains;
    tpbc_pkg::t_cmd   w_cmd;
    logic signed [15:0] w_tilt;
    logic [7:0]         w_drive;

    tpbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    tpbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    tpbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_gains       (w_gains),
        .i_accel_x     (s_axis_tdata[15:0]),
        .i_accel_y     (s_axis_tdata[31:16]),
        .i_accel_z     (s_axis_tdata[47:32]),
        .o_tilt_deg    (w_tilt),
        .o_drive_level (w_drive),
        .o_go_forward  (m_axis_tuser)
    );

    assign m_axis_tdata = {w_drive, w_tilt};

endmodule

// ===== test/tb_top.sv =====
// Testbench for the tilt PID balance controller: directed table, then random samples.
// Predicts pitch, drive and direction from its own CORDIC/PID model and checks each result.
// Depends on tpbc_pkg and tilt_pid_balance_controller_top.
module tb_top;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] tilt;
        logic [7:0]         drive;
        logic               fwd;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // accel_x, accel_y, accel_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // tilt_deg, drive_level
    logic        m_axis_tuser;        // go_forward

    tilt_pid_balance_controller_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    localparam longint ATAN_LUT [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    // predictor state
    longint kp, ki, kd, tgt, err_acc, err_last;
    t_result expected_q[$];
    int errors = 0, n_sent = 0, n_seen = 0;
    int src_idle = 0, snk_stall = 0, hold_cycles = 0;

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint pitch_q88(longint ax, longint ay, longint az);
        longint x, y, z = 0, xs, ys, m, q;
        if (ax == 0) return 0;
        x = root_floor(longint'(ay * ay + az * az)) * 256;
        y = ax * 256;
        for (int i = 0; i < tpbc_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_LUT[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_LUT[i];
            end
        end
        m = z < 0 ? -z : z;
        q = (m * 1260 + 46137344) / 92274688;
        if (q > 23040) q = 23040;
        return z < 0 ? -q : q;
    endfunction

    function automatic t_result balance_step(t_sample s);
        t_result r;
        longint t, e, sum, d, acc, smax, smin;
        longint unsigned mag;
        t = pitch_q88(s.ax, s.ay, s.az);
        e = tgt - t;
        smax = (64'sd1 <<< (tpbc_pkg::SUM_BITS - 1)) - 1;
        smin = -smax - 1;
        sum = err_acc + e;
        if (sum > smax) sum = smax;
        if (sum < smin) sum = smin;
        err_acc = sum;
        d = e - err_last;
        acc = kp * e + ki * sum + kd * d;
        mag = acc < 0 ? -acc : acc;
        r.drive = (mag > 5898240) ? 8'd255 : 8'(mag * 255 / 5898240);
        err_last = e;
        r.tilt = 16'(t);
        r.fwd = t > 0;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic signed [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tpbc_pkg::REG_GAIN_PROP:   kp = val;
            tpbc_pkg::REG_GAIN_INTEG:  ki = val;
            tpbc_pkg::REG_GAIN_DERIV:  kd = val;
            tpbc_pkg::REG_TARGET_TILT: tgt = val;
        endcase
    endtask

    task automatic setup_gains(logic signed [15:0] p, i, d, t);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        write_reg(tpbc_pkg::REG_GAIN_PROP, p);
        write_reg(tpbc_pkg::REG_GAIN_INTEG, i);
        write_reg(tpbc_pkg::REG_GAIN_DERIV, d);
        write_reg(tpbc_pkg::REG_TARGET_TILT, t);
    endtask

    task automatic push_sample(t_sample s, bit has_gold = 0, t_result gold = '0);
        while (src_idle > 0 && $urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.az, s.ay, s.ax};
        do @(posedge i_clk); while (!s_axis_tready);
        begin
            t_result r = balance_step(s);
            if (has_gold && r !== gold)
                $display("%0t directed row inconsistent: table %h model %h", $time, gold, r);
            expected_q.push_back(has_gold ? gold : r);
        end
        n_sent++;
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        case ($urandom_range(5))
            0: s = {16'($urandom), 16'($urandom), 16'($urandom)};
            1: s = {16'($urandom), 16'sd0, 16'sd0};
            2: s = {16'sd0, 16'($urandom), 16'($urandom)};
            default: begin
                s.ax = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
                s.ay = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
                s.az = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            end
        endcase
        return s;
    endfunction

    // receiver with random stall and one long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(snk_stall > 0 && $urandom_range(99) < snk_stall);
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            t_result got, want;
            got = {m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser};
            n_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.tilt !== want.tilt) begin
                    $display("%0t tilt exp %0d got %0d", $time, want.tilt, got.tilt);
                    errors++;
                end
                if (got.drive !== want.drive) begin
                    $display("%0t drive exp %0d got %0d", $time, want.drive, got.drive);
                    errors++;
                end
                if (got.fwd !== want.fwd) begin
                    $display("%0t fwd exp %0b got %0b", $time, want.fwd, got.fwd);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

    typedef struct {
        t_sample s;
        bit      gold_ok;
        t_result gold;
    } t_row;

    t_row directed [13] = '{
        '{'{16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd0, 8'd0, 1'b0}},
        '{'{16'sd0, 16'sh7fff, 16'sh8000}, 1, '{16'sd0, 8'd0, 1'b0}},
        '{'{16'sh7fff, 16'sd0, 16'sd0}, 0, '0},
        '{'{16'sh8000, 16'sd0, 16'sd0}, 0, '0},
        '{'{16'sd16384, 16'sd0, 16'sd16384}, 0, '0},
        '{'{-16'sd16384, 16'sd0, 16'sd16384}, 0, '0},
        '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, '0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 0, '0},
        '{'{16'sd1, 16'sh8000, 16'sh8000}, 0, '0},
        '{'{-16'sd1, 16'sd0, 16'sd1}, 0, '0},
        '{'{16'sd100, 16'sd0, 16'sh8000}, 0, '0},
        '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 0, '0},
        '{'{16'shaaaa, 16'sh5555, 16'shaaaa}, 0, '0}
    };

    initial begin
        kp = 0; ki = 0; kd = 0; tgt = 0; err_acc = 0; err_last = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k])
            push_sample(directed[k].s, directed[k].gold_ok, directed[k].gold);
        setup_gains(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd23040);
        foreach (directed[k]) push_sample(directed[k].s);
        setup_gains(16'sh8000, 16'sh8000, 16'sh8000, -16'sd23040);
        foreach (directed[k]) push_sample(directed[k].s);
        setup_gains(16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff);
        for (int k = 0; k < 6; k++) push_sample(rand_sample());

        for (int ph = 0; ph < 8; ph++) begin
            setup_gains(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 15)),
                        16'($urandom_range(0, 511)),
                        $signed(16'($urandom_range(0, 2 * 23040))) - 16'sd23040);
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 50; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 50; end
                3: begin src_idle = 25; snk_stall = 25; end
            endcase
            if (ph == 2) hold_cycles = 400;
            for (int k = 0; k < 238; k++) push_sample(rand_sample());
        end
        src_idle = 0; snk_stall = 0;
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d samples over 11 gain settings, %0d results checked.", n_sent, n_seen);
        $display("Covered idle/stall mixes and a long output hold-off.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tpbc_pkg.sv
rtl/tpbc_regs.sv
rtl/tpbc_ctrl.sv
rtl/tpbc_dp.sv
rtl/tilt_pid_balance_controller_top.sv
test/tb_top.sv
